[rtl/tmxd_pkg.sv]
// Package of the three-mode xor delta decoder: field widths, register indexes,
// mode codes and the control record that moves between the pipeline stages.
// It depends on nothing else.
package tmxd_pkg;

	localparam int DATA_W     = 8;
	localparam int WORD_W     = 16;
	localparam int IDX_W      = 6;
	localparam int LEN_W      = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Default depth of the high-byte plane.
	localparam int MAX_WORDS_DEF = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOB_LENGTH  = 1'd1;

	// Decode modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_COPY  = 2'd0,
		MODE_PLANE = 2'd1,
		MODE_WORD  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// One item as it stands in the first pipeline stage.
	typedef struct packed {
		logic              clr;       // first byte of a job: running value restarts
		logic              emit;      // the item gives a word
		logic              xor_en;    // the word goes through the running xor
		logic              use_plane; // high byte comes from the plane memory
		logic [DATA_W-1:0] lo_byte;
		logic [DATA_W-1:0] hi_byte;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} s1_t;

endpackage

[rtl/tmxd_plane_ram.sv]
// High-byte plane memory of the decoder: one write port and one read port,
// with the read data registered. It depends on nothing else.
module tmxd_plane_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Writes take effect at the clock edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Reads are registered and hold while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tmxd_front.sv]
// Front stage of the decoder: configuration registers, byte position, pairing
// of bytes and the access to the plane memory. It depends on tmxd_pkg.
module tmxd_front #(
	parameter int MAX_WORDS = tmxd_pkg::MAX_WORDS_DEF,
	parameter int AW        = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tmxd_pkg::DATA_W-1:0]     data_byte,
	input  logic                            cfg_we,
	input  logic [tmxd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmxd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s1_take,
	output logic                            s1_valid_s1,
	output tmxd_pkg::s1_t                   s1_s1,
	output logic                            mem_we,
	output logic [AW-1:0]                   mem_waddr,
	output logic [tmxd_pkg::DATA_W-1:0]     mem_wdata,
	output logic                            mem_re,
	output logic [AW-1:0]                   mem_raddr
);

	tmxd_pkg::mode_t                 mode_q;
	logic [tmxd_pkg::LEN_W-1:0]      len_q;
	logic [tmxd_pkg::LEN_W-1:0]      pos_q;
	logic [tmxd_pkg::DATA_W-1:0]     pend_q;

	logic                            accept;
	logic [tmxd_pkg::LEN_W-2:0]      c_raw;
	logic [tmxd_pkg::LEN_W-2:0]      count;
	logic [tmxd_pkg::LEN_W-1:0]      count_x;
	logic [tmxd_pkg::LEN_W-1:0]      two_c;
	logic                            in_first;
	logic                            in_pair;
	logic [tmxd_pkg::LEN_W-1:0]      plane_idx;
	logic [tmxd_pkg::LEN_W-1:0]      idx_full;
	logic [tmxd_pkg::LEN_W:0]        pos_inc;
	logic [tmxd_pkg::LEN_W-1:0]      pos_next;
	logic                            pend_we;
	tmxd_pkg::s1_t                   s1_d;

	// The stage takes a new item unless it holds one that cannot move on.
	assign in_stall = s1_valid_s1 && !s1_take;
	assign accept   = in_valid && !in_stall;

	// Words in the job: odd lengths of three or more, within the plane depth.
	always_comb begin
		c_raw = len_q[tmxd_pkg::LEN_W-1:1];
		if (!len_q[0] || len_q < tmxd_pkg::LEN_W'(3)
			|| 32'(c_raw) > 32'(MAX_WORDS)) begin
			count = '0;
		end else begin
			count = c_raw;
		end
	end

	assign count_x   = {1'b0, count};
	assign two_c     = {count, 1'b0};
	assign in_first  = pos_q < count_x;
	assign in_pair   = pos_q < two_c;
	assign plane_idx = pos_q - count_x;
	assign pos_inc   = {1'b0, pos_q} + 9'd1;
	assign pos_next  = (pos_inc >= {1'b0, len_q}) ? '0 : pos_inc[tmxd_pkg::LEN_W-1:0];

	// Classify the byte by mode and position.
	always_comb begin
		s1_d           = '0;
		s1_d.clr       = (pos_q == '0);
		pend_we        = 1'b0;
		mem_we         = 1'b0;
		mem_re         = 1'b0;
		idx_full       = '0;
		case (mode_q)
			tmxd_pkg::MODE_COPY, tmxd_pkg::MODE_WORD: begin
				idx_full = {1'b0, pos_q[tmxd_pkg::LEN_W-1:1]};
				if (in_pair) begin
					if (!pos_q[0]) begin
						pend_we = accept;
					end else begin
						s1_d.emit   = 1'b1;
						s1_d.xor_en = (mode_q == tmxd_pkg::MODE_WORD);
					end
				end
			end
			tmxd_pkg::MODE_PLANE: begin
				idx_full = plane_idx;
				if (in_first) begin
					mem_we = accept;
				end else if (in_pair) begin
					s1_d.emit      = 1'b1;
					s1_d.xor_en    = 1'b1;
					s1_d.use_plane = 1'b1;
					mem_re         = accept;
				end
			end
			default: begin
				idx_full = '0;
			end
		endcase
		s1_d.lo_byte = s1_d.use_plane ? data_byte : pend_q;
		s1_d.hi_byte = data_byte;
		s1_d.idx     = idx_full[tmxd_pkg::IDX_W-1:0];
		s1_d.last    = (tmxd_pkg::LEN_W'(idx_full + 8'd1) == count_x);
	end

	assign mem_waddr = AW'(pos_q);
	assign mem_wdata = data_byte;
	assign mem_raddr = AW'(plane_idx);

	// Configuration registers and byte position; a write restarts the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tmxd_pkg::MODE_COPY;
			len_q  <= '0;
			pos_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == tmxd_pkg::REG_DECODE_MODE) begin
				mode_q <= tmxd_pkg::mode_t'(cfg_data[tmxd_pkg::MODE_W-1:0]);
			end
			if (cfg_index == tmxd_pkg::REG_JOB_LENGTH) begin
				len_q <= cfg_data[tmxd_pkg::LEN_W-1:0];
			end
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= pos_next;
		end
	end

	// Low byte held until its partner arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pend_we) begin
			pend_q <= data_byte;
		end
	end

	// First pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_take) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

endmodule

[rtl/tmxd_back.sv]
// Back stage of the decoder: forms the word, keeps the running xor and holds
// the output register. It depends on tmxd_pkg.
module tmxd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          s1_valid_s1,
	input  tmxd_pkg::s1_t                 s1_s1,
	input  logic [tmxd_pkg::DATA_W-1:0]   mem_rdata,
	output logic                          s1_take,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmxd_pkg::WORD_W-1:0]   out_word,
	output logic [tmxd_pkg::IDX_W-1:0]    word_index,
	output logic                          last_word
);

	logic [tmxd_pkg::WORD_W-1:0] rx_q;
	logic [tmxd_pkg::WORD_W-1:0] word;
	logic [tmxd_pkg::WORD_W-1:0] rx_base;
	logic [tmxd_pkg::WORD_W-1:0] rx_next;
	logic                        advance;

	// An item without a word always moves on; one with a word needs room.
	assign s1_take = !s1_s1.emit || !out_valid || !out_stall;
	assign advance = s1_valid_s1 && s1_take;

	// Word assembly and running xor.
	always_comb begin
		word    = {(s1_s1.use_plane ? mem_rdata : s1_s1.hi_byte), s1_s1.lo_byte};
		rx_base = s1_s1.clr ? '0 : rx_q;
		rx_next = s1_s1.xor_en ? (rx_base ^ word) : rx_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= '0;
		end else if (cfg_we) begin
			rx_q <= '0;
		end else if (advance) begin
			rx_q <= rx_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && s1_s1.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_s1.emit) begin
			out_word   <= s1_s1.xor_en ? rx_next : word;
			word_index <= s1_s1.idx;
			last_word  <= s1_s1.last;
		end
	end

endmodule

[rtl/three_mode_xor_delta_decoder.sv]
// Top level of the three-mode xor delta decoder; it joins the front stage,
// the high-byte plane memory and the back stage. It depends on tmxd_pkg.
//
// The decoder takes one byte in every cycle while the output is taken; the
// byte that completes a word passes the first-stage register and then the
// output register. The first stage counts the byte and issues its single
// access to the plane memory (a write while the high bytes of a job are
// stored, a read once the low bytes arrive), and the second stage joins the
// registered read data, updates the running xor and fills the output
// register. Each byte makes at most one memory access and one xor. The plane is
// filled by every byte-plane job before it is read and needs no clearing after
// reset. The user must see that registers are written only while no item is
// in flight; the block does not enforce it, and a write restarts the current job.
module three_mode_xor_delta_decoder #(
	parameter int MAX_WORDS = tmxd_pkg::MAX_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tmxd_pkg::DATA_W-1:0]     data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tmxd_pkg::WORD_W-1:0]     out_word,
	output logic [tmxd_pkg::IDX_W-1:0]      word_index,
	output logic                            last_word,
	input  logic                            cfg_we,
	input  logic [tmxd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmxd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	logic                        s1_take;
	logic                        s1_valid_s1;
	tmxd_pkg::s1_t               s1_s1;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tmxd_pkg::DATA_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [tmxd_pkg::DATA_W-1:0] mem_rdata;

	tmxd_front #(
		.MAX_WORDS (MAX_WORDS),
		.AW        (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s1_take     (s1_take),
		.s1_valid_s1 (s1_valid_s1),
		.s1_s1       (s1_s1),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	tmxd_plane_ram #(
		.DEPTH (MAX_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tmxd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.s1_valid_s1 (s1_valid_s1),
		.s1_s1       (s1_s1),
		.mem_rdata   (mem_rdata),
		.s1_take     (s1_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// A byte either stores a high byte or reads one, never both.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("plane memory written and read by the same item");

	// The input stalls only behind an item held in the first stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1)
		else $error("input stalled with an empty first stage");

	// An item held in the first stage stays there and keeps its read data.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_take && s1_s1.use_plane)
		|=> (s1_valid_s1 && $stable(mem_rdata)))
		else $error("held item lost or its plane data changed");

endmodule
